// ===== rtl/json_string_unescape_utf8_top_assert.svh =====
// Assertion macros shared by the JSON unescaper modules.
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define JSU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/jsu_pkg.sv =====
// Types and constants shared by the JSON unescaper modules.
package jsu_pkg;

  localparam int JSU_QDEPTH = 4;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_BSL  = 3'd4,
    PH_LOWU = 3'd5,
    PH_HEX2 = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    K_BYTE  = 2'd0,
    K_CLOSE = 2'd1,
    K_ERR   = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    E_NONE      = 4'd0,
    E_NO_QUOTE  = 4'd1,
    E_CONTROL   = 4'd2,
    E_BAD_ESC   = 4'd3,
    E_HEX       = 4'd4,
    E_NO_LOW    = 4'd5,
    E_BAD_LOW   = 4'd6,
    E_LONE_LOW  = 4'd7,
    E_NUL       = 4'd8,
    E_UNTERM    = 4'd9
  } err_t;

  // One job: the results caused by one text byte.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    kind_t           kind;
    err_t            err;
  } job_t;

endpackage

// ===== rtl/json_string_unescape_utf8_top.sv =====
// Top level of the JSON string unescaper with UTF-8 output.
// Feed the raw bytes of a JSON string literal, opening quote first, through the
// push/full queue port; text_end marks end of text. Decoded UTF-8 bytes, a
// string-closed marker or an error come out through the empty/pop queue port,
// with last set on the final result caused by each text byte. A text byte is
// taken in every cycle while full is low: the front phase machine handles one
// byte per cycle and full rises only when the job queue (QDEPTH jobs) is
// stocked. Results leave at one per cycle from the serialiser while pop is
// high, which sets the sustained rate when escapes expand into two to four
// UTF-8 bytes. The first result of a byte is written into the job queue and
// then loaded into the serialiser's result register before it is visible.
module json_string_unescape_utf8_top
  import jsu_pkg::*;
#(
  parameter int QDEPTH = JSU_QDEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte,
  input  logic       text_end,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic [3:0] error_code,
  output logic       last
);

  logic accept;
  logic job_valid;
  job_t job;
  logic q_full;
  logic q_nonempty;
  logic q_rd;
  job_t q_job;

  // Hold input while the queue has no room for a job.
  assign full   = q_full;
  assign accept = push && !q_full;

  // Classify each byte and advance the escape state.
  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .text_byte (text_byte),
    .text_end  (text_end),
    .job_valid (job_valid),
    .job       (job)
  );

  // Bytes that cause no result push no job.
  jsu_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (accept && job_valid),
    .wr_job   (job),
    .rd       (q_rd),
    .rd_job   (q_job),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  // Serialise each job into result transactions.
  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_job      (q_job),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .kind       (kind),
    .error_code (error_code),
    .last       (last)
  );

endmodule

// ===== rtl/jsu_front.sv =====
// Front end: phase machine that classifies each text byte into a job.
module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] text_byte,
  input  logic       text_end,
  output logic       job_valid,
  output job_t       job
);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_U     = 8'h75;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } enc_t;

  phase_t      phase, phase_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] high_unit, high_unit_next;
  logic [15:0] hex_accum, hex_accum_next;

  logic        do_fail;
  err_t        fail_code;
  logic [3:0]  digit;
  logic        digit_ok;
  logic [15:0] unit;
  logic [20:0] pair_cp;
  enc_t        enc;

  function automatic enc_t utf8_enc(input logic [20:0] cp);
    enc_t r;
    r = '0;
    if (cp <= 21'h7f) begin
      r.bytes[0] = cp[7:0];
      r.last_idx = 2'd0;
    end else if (cp <= 21'h7ff) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.last_idx = 2'd1;
    end else if (cp <= 21'hffff) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.last_idx = 2'd2;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.last_idx = 2'd3;
    end
    return r;
  endfunction

  always_comb begin
    digit    = 4'd0;
    digit_ok = 1'b0;
    if (text_byte >= 8'h30 && text_byte <= 8'h39) begin
      digit    = 4'(text_byte - 8'h30);
      digit_ok = 1'b1;
    end else if (text_byte >= 8'h61 && text_byte <= 8'h66) begin
      digit    = 4'(text_byte - 8'h57);
      digit_ok = 1'b1;
    end else if (text_byte >= 8'h41 && text_byte <= 8'h46) begin
      digit    = 4'(text_byte - 8'h37);
      digit_ok = 1'b1;
    end
    if (text_end) digit_ok = 1'b0;
  end

  assign unit    = {hex_accum[11:0], digit};
  assign pair_cp = {1'b0, high_unit[9:0], unit[9:0]} + 21'h10000;

  always_comb begin
    phase_next     = phase;
    hex_count_next = hex_count;
    high_unit_next = high_unit;
    hex_accum_next = hex_accum;
    do_fail        = 1'b0;
    fail_code      = E_NONE;
    job_valid      = 1'b0;
    job            = '0;
    job.kind       = K_BYTE;
    job.err        = E_NONE;
    enc            = '0;

    unique case (phase)
      PH_BODY: begin
        if (text_end) begin
          do_fail = 1'b1; fail_code = E_UNTERM;
        end else if (text_byte == CH_QUOTE) begin
          job_valid  = 1'b1;
          job.kind   = K_CLOSE;
          phase_next = PH_WAIT;
        end else if (text_byte < 8'h20) begin
          do_fail = 1'b1; fail_code = E_CONTROL;
        end else if (text_byte == CH_BSL) begin
          phase_next = PH_ESC;
        end else begin
          job_valid    = 1'b1;
          job.bytes[0] = text_byte;
        end
      end
      PH_ESC: begin
        if (text_end) begin
          do_fail = 1'b1; fail_code = E_BAD_ESC;
        end else begin
          phase_next = PH_BODY;
          job_valid  = 1'b1;
          case (text_byte)
            CH_QUOTE, CH_BSL, CH_SLASH: job.bytes[0] = text_byte;
            8'h62:   job.bytes[0] = 8'h08;
            8'h66:   job.bytes[0] = 8'h0c;
            8'h6e:   job.bytes[0] = 8'h0a;
            8'h72:   job.bytes[0] = 8'h0d;
            8'h74:   job.bytes[0] = 8'h09;
            CH_U: begin
              job_valid      = 1'b0;
              phase_next     = PH_HEX1;
              hex_count_next = 2'd0;
              hex_accum_next = 16'd0;
            end
            default: begin
              job_valid = 1'b0;
              do_fail   = 1'b1; fail_code = E_BAD_ESC;
            end
          endcase
        end
      end
      PH_HEX1, PH_HEX2: begin
        if (!digit_ok) begin
          do_fail = 1'b1; fail_code = E_HEX;
        end else if (hex_count != 2'd3) begin
          hex_count_next = hex_count + 2'd1;
          hex_accum_next = unit;
        end else begin
          hex_count_next = 2'd0;
          hex_accum_next = 16'd0;
          if (phase == PH_HEX1) begin
            if (unit >= 16'hd800 && unit <= 16'hdbff) begin
              high_unit_next = unit;
              phase_next     = PH_BSL;
            end else if (unit >= 16'hdc00 && unit <= 16'hdfff) begin
              do_fail = 1'b1; fail_code = E_LONE_LOW;
            end else if (unit == 16'd0) begin
              do_fail = 1'b1; fail_code = E_NUL;
            end else begin
              enc        = utf8_enc({5'd0, unit});
              job_valid  = 1'b1;
              job.bytes  = enc.bytes;
              job.last_idx = enc.last_idx;
              phase_next = PH_BODY;
            end
          end else begin
            if (unit < 16'hdc00 || unit > 16'hdfff) begin
              do_fail = 1'b1; fail_code = E_BAD_LOW;
            end else begin
              enc            = utf8_enc(pair_cp);
              job_valid      = 1'b1;
              job.bytes      = enc.bytes;
              job.last_idx   = enc.last_idx;
              high_unit_next = 16'd0;
              phase_next     = PH_BODY;
            end
          end
        end
      end
      PH_BSL: begin
        if (text_end || text_byte != CH_BSL) begin
          do_fail = 1'b1; fail_code = E_NO_LOW;
        end else begin
          phase_next = PH_LOWU;
        end
      end
      PH_LOWU: begin
        if (text_end || text_byte != CH_U) begin
          do_fail = 1'b1; fail_code = E_NO_LOW;
        end else begin
          phase_next     = PH_HEX2;
          hex_count_next = 2'd0;
          hex_accum_next = 16'd0;
        end
      end
      default: begin
        if (!text_end && text_byte == CH_QUOTE) begin
          phase_next     = PH_BODY;
          hex_count_next = 2'd0;
          high_unit_next = 16'd0;
          hex_accum_next = 16'd0;
        end else begin
          do_fail = 1'b1; fail_code = E_NO_QUOTE;
        end
      end
    endcase

    // Any error drops back to waiting with the escape state cleared.
    if (do_fail) begin
      job_valid      = 1'b1;
      job            = '0;
      job.kind       = K_ERR;
      job.err        = fail_code;
      phase_next     = PH_WAIT;
      hex_count_next = 2'd0;
      high_unit_next = 16'd0;
      hex_accum_next = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_WAIT;
      hex_count <= 2'd0;
      high_unit <= 16'd0;
      hex_accum <= 16'd0;
    end else if (accept) begin
      phase     <= phase_next;
      hex_count <= hex_count_next;
      high_unit <= high_unit_next;
      hex_accum <= hex_accum_next;
    end
  end

endmodule

// ===== rtl/jsu_queue.sv =====
// Short job queue between the front end and the byte serialiser.
`include "json_string_unescape_utf8_top_assert.svh"
module jsu_queue
  import jsu_pkg::*;
#(
  parameter int DEPTH = JSU_QDEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wr_job,
  input  logic rd,
  output job_t rd_job,
  output logic full,
  output logic nonempty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  job_t          store [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  assign full     = (count == CNT_FULL);
  assign nonempty = (count != '0);
  assign rd_job   = store[rptr];

  always_ff @(posedge clk) begin
    if (wr) store[wptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
      if (rd) rptr <= (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
      if (wr && !rd) count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

  `JSU_ASSERT_IMPL(a_no_overflow, wr, count != CNT_FULL, "job queue written while full")
  `JSU_ASSERT_IMPL(a_no_underflow, rd, count != '0, "job queue read while empty")
  `JSU_ASSERT_IMPL(a_count_bound, 1'b1, count <= CNT_FULL, "job queue count out of range")

endmodule

// ===== rtl/jsu_back.sv =====
// Back end: hands out the bytes of each job one result at a time.
`include "json_string_unescape_utf8_top_assert.svh"
module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_nonempty,
  input  job_t       q_job,
  output logic       q_rd,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic [3:0] error_code,
  output logic       last
);

  job_t       cur;
  logic       valid;
  logic [1:0] idx;
  logic       taken;
  logic       at_last;

  assign at_last = (idx == cur.last_idx);
  assign taken   = valid && pop;
  assign q_rd    = q_nonempty && (!valid || (taken && at_last));

  assign empty      = !valid;
  assign out_byte   = cur.bytes[idx];
  assign kind       = cur.kind;
  assign error_code = cur.err;
  assign last       = at_last;

  always_ff @(posedge clk) begin
    if (q_rd) cur <= q_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else if (q_rd) begin
      valid <= 1'b1;
      idx   <= 2'd0;
    end else if (taken) begin
      if (at_last) valid <= 1'b0;
      else idx <= idx + 2'd1;
    end
  end

  `JSU_ASSERT_IMPL(a_marker_single, valid && cur.kind != K_BYTE, cur.last_idx == 2'd0,
                   "close or error result spans several bytes")
  `JSU_ASSERT_NEXT(a_hold_unpopped, valid && !pop, valid && $stable(idx),
                   "waiting result moved without being popped")
  `JSU_ASSERT_IMPL(a_idx_bound, valid, idx <= cur.last_idx, "byte index past end of job")

endmodule
